/* rtl/alle_pkg.sv */
// shared types, constants and beat layout of the array linked list engine
package alle_pkg;

   localparam int ALLE_CAPACITY     = 32;
   localparam int ALLE_PAYLOAD_BITS = 32;

   // longest dump, in result beats
   localparam int DUMP_MAX   = 32;
   localparam int DUMP_CNT_W = $clog2(DUMP_MAX);

   // field widths of the stream beats
   localparam int ACTION_W      = 2;
   localparam int DATA_W        = 32;
   localparam int SLOT_FIELD_W  = 5;
   localparam int STATUS_W      = 2;
   localparam int COUNT_FIELD_W = 6;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = ACTION_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_USED_W  = STATUS_W + SLOT_FIELD_W + DATA_W + COUNT_FIELD_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT  = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_DUMP    = 2'd2,
      ACT_UNKNOWN = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOT_USED = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       ins_rd;
      logic       ins_link;
      logic       ins_tail;
      logic       rem_rd;
      logic       rem_fwd;
      logic       rem_back;
      logic       rem_free;
      logic       dmp_rd;
      logic       rsp_load;
      logic       rsp_dump;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                fh_nil;
      logic                slot_bad;
      logic                head_nil;
      logic                out_free;
      logic                dmp_last;
   } flag_type;

endpackage

/* rtl/array_linked_list_engine_core.sv */
// top level of the array linked list engine
//
// A pool of CAPACITY slots holds a doubly linked list; unused slots sit on a
// free chain, slot 0 first after reset. Each req_ beat carries one command in
// req_tuser: insert a payload at the tail, remove a slot by handle, or dump
// the list from head to tail. Each insert, remove or dump gives rsp_ beats;
// the final one of a command has rsp_tlast high. Action code 3 is taken and dropped.
//
// One command is worked on at a time; req_tready is high only while the
// controller is idle. An insert steps through read, link and tail states, a
// remove through read, forward, back and free, a rejected command straight
// to the result; all follow the dependent reads and writes on the single
// write port link memories. A dump works each entry as link read, result load.
//
// The result sits in an output register, so the next command is taken while
// the last result waits. When rsp_tready is low the engine holds in its
// result state until the register is free. Reset (synchronous) empties the
// list at once, with no clearing pass.
module array_linked_list_engine_core
   import alle_pkg::*;
#(
   parameter int CAPACITY     = ALLE_CAPACITY,
   parameter int PAYLOAD_BITS = ALLE_PAYLOAD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // payload_in, slot_in
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // status, slot_out, payload_out, entry_count
   output logic                   rsp_tlast
);

   cmd_type  cmd;
   flag_type flags;

   alle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   alle_dp #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .flags      (flags)
   );

endmodule

/* rtl/alle_ram.sv */
// generic single write port ram with registered read
module alle_ram
   import alle_pkg::*;
#(
   parameter int WIDTH = ALLE_PAYLOAD_BITS,
   parameter int DEPTH = ALLE_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/alle_ctrl.sv */
// controller state machine sequencing insert, remove and dump
module alle_ctrl
   import alle_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  flag_type flags,
   output cmd_type  cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_INS_RD   = 11'b000_0000_0010,
      ST_INS_LINK = 11'b000_0000_0100,
      ST_INS_TAIL = 11'b000_0000_1000,
      ST_REM_RD   = 11'b000_0001_0000,
      ST_REM_FWD  = 11'b000_0010_0000,
      ST_REM_BACK = 11'b000_0100_0000,
      ST_REM_FREE = 11'b000_1000_0000,
      ST_DMP_RD   = 11'b001_0000_0000,
      ST_DMP_OUT  = 11'b010_0000_0000,
      ST_RESP     = 11'b100_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (flags.action)
                  ACT_INSERT: begin
                     if (flags.fh_nil) begin
                        status_in = STAT_FULL;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  ACT_REMOVE: begin
                     if (flags.slot_bad) begin
                        status_in = STAT_NOT_USED;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_REM_RD;
                     end
                  end
                  ACT_DUMP: begin
                     if (flags.head_nil) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_DMP_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_RD: begin
            cmd.ins_rd = 1'b1;
            state_in   = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = ST_INS_TAIL;
         end
         ST_INS_TAIL: begin
            cmd.ins_tail = 1'b1;
            status_in    = STAT_OK;
            state_in     = ST_RESP;
         end
         ST_REM_RD: begin
            cmd.rem_rd = 1'b1;
            state_in   = ST_REM_FWD;
         end
         ST_REM_FWD: begin
            cmd.rem_fwd = 1'b1;
            state_in    = ST_REM_BACK;
         end
         ST_REM_BACK: begin
            cmd.rem_back = 1'b1;
            state_in     = ST_REM_FREE;
         end
         ST_REM_FREE: begin
            cmd.rem_free = 1'b1;
            status_in    = STAT_OK;
            state_in     = ST_RESP;
         end
         ST_DMP_RD: begin
            cmd.dmp_rd = 1'b1;
            state_in   = ST_DMP_OUT;
         end
         ST_DMP_OUT: begin
            if (flags.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_dump   = 1'b1;
               cmd.rsp_status = STAT_OK;
               state_in       = flags.dmp_last ? ST_IDLE : ST_DMP_RD;
            end
         end
         ST_RESP: begin
            if (flags.out_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

endmodule

/* rtl/alle_dp.sv */
// datapath: link and payload memories, list pointers and the result register
module alle_dp
   import alle_pkg::*;
#(
   parameter int CAPACITY     = ALLE_CAPACITY,
   parameter int PAYLOAD_BITS = ALLE_PAYLOAD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   input  cmd_type                cmd,
   output flag_type               flags
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int LINK_W = $clog2(CAPACITY + 1);
   localparam int CNT_W  = LINK_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

   // request fields
   logic [DATA_W-1:0]       payload_in;
   logic [SLOT_FIELD_W-1:0] slot_in;
   logic [ACTION_W-1:0]     action;

   // list state
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [LINK_W-1:0]   fh_ff, fh_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAPACITY-1:0] in_use_ff, in_use_in;
   logic [CAPACITY-1:0] nv_ff, nv_in;

   // working registers
   logic [LINK_W-1:0]       cur_ff, cur_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [LINK_W-1:0]       p_ff, p_in;
   logic [LINK_W-1:0]       n_ff, n_in;
   logic [DUMP_CNT_W-1:0]   k_ff, k_in;
   logic                    nrd_v_ff;
   logic [SLOT_W-1:0]       nrd_a_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic [SLOT_FIELD_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [DATA_W-1:0]        rsp_pay_ff, rsp_pay_in;
   logic [COUNT_FIELD_W-1:0] rsp_cnt_ff;
   logic                     rsp_last_ff, rsp_last_in;

   // memory ports
   logic                    nwr_en, prwr_en;
   logic [SLOT_W-1:0]       nwr_addr, prwr_addr;
   logic [LINK_W-1:0]       nwr_data, prwr_data;
   logic                    nrd_en;
   logic [SLOT_W-1:0]       nrd_addr;
   logic [LINK_W-1:0]       next_rdata, prev_rdata;
   logic [PAYLOAD_BITS-1:0] pay_rdata;

   // width adaptation
   logic [SLOT_W+SLOT_FIELD_W-1:0]       slot_ext;
   logic [LINK_W+SLOT_FIELD_W-1:0]       slot_link_ext;
   logic [LINK_W+SLOT_FIELD_W-1:0]       cur_ext;
   logic [PAYLOAD_BITS+DATA_W-1:0]       pay_in_ext;
   logic [PAYLOAD_BITS+DATA_W-1:0]       pay_out_ext;
   logic [CNT_W+COUNT_FIELD_W-1:0]       cnt_ext;
   logic [SLOT_W-1:0]                    slot_idx;
   logic [LINK_W-1:0]                    slot_link;
   logic [LINK_W-1:0]                    next_val;
   logic                                 dmp_last;

   logic [SLOT_W-1:0] cur_idx, tail_idx, fh_idx, p_rd_idx, n_idx;

   assign payload_in = req_tdata[DATA_W-1:0];
   assign slot_in    = req_tdata[DATA_W+SLOT_FIELD_W-1:DATA_W];
   assign action     = req_tuser;

   assign slot_ext      = {{SLOT_W{1'b0}}, slot_in};
   assign slot_idx      = slot_ext[SLOT_W-1:0];
   assign slot_link_ext = {{LINK_W{1'b0}}, slot_in};
   assign slot_link     = slot_link_ext[LINK_W-1:0];
   assign pay_in_ext    = {{PAYLOAD_BITS{1'b0}}, payload_in};
   assign pay_out_ext   = {{DATA_W{1'b0}}, pay_rdata};
   assign cur_ext       = {{SLOT_FIELD_W{1'b0}}, cur_ff};
   assign cnt_ext       = {{COUNT_FIELD_W{1'b0}}, count_ff};

   assign cur_idx  = cur_ff[SLOT_W-1:0];
   assign tail_idx = tail_ff[SLOT_W-1:0];
   assign fh_idx   = fh_ff[SLOT_W-1:0];
   assign p_rd_idx = prev_rdata[SLOT_W-1:0];
   assign n_idx    = n_ff[SLOT_W-1:0];

   // a never written next link reads as its reset value, the following slot
   assign next_val = nrd_v_ff ? next_rdata : LINK_W'({1'b0, nrd_a_ff}) + LINK_W'(1);
   assign dmp_last = (next_val == NIL) || (k_ff == DUMP_CNT_W'(DUMP_MAX - 1));

   assign flags.action   = action;
   assign flags.fh_nil   = (fh_ff == NIL);
   assign flags.slot_bad = (32'(slot_in) >= 32'(CAPACITY)) || !in_use_ff[slot_idx];
   assign flags.head_nil = (head_ff == NIL);
   assign flags.out_free = !rsp_valid_ff || rsp_tready;
   assign flags.dmp_last = dmp_last;

   always_comb begin
      nwr_en    = 1'b0;
      nwr_addr  = cur_idx;
      nwr_data  = NIL;
      prwr_en   = 1'b0;
      prwr_addr = cur_idx;
      prwr_data = tail_ff;
      nrd_en    = 1'b0;
      nrd_addr  = cur_idx;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fh_in     = fh_ff;
      count_in  = count_ff;
      in_use_in = in_use_ff;
      cur_in    = cur_ff;
      pay_in    = pay_ff;
      p_in      = p_ff;
      n_in      = n_ff;
      k_in      = k_ff;

      if (cmd.capture) begin
         pay_in = pay_in_ext[PAYLOAD_BITS-1:0];
         k_in   = '0;
         case (action)
            ACT_INSERT: cur_in = fh_ff;
            ACT_REMOVE: cur_in = slot_link;
            default:    cur_in = head_ff;
         endcase
      end

      if (cmd.ins_rd || cmd.rem_rd || cmd.dmp_rd) begin
         nrd_en = 1'b1;
      end

      if (cmd.ins_link) begin
         fh_in     = next_val;
         nwr_en    = 1'b1;
         prwr_en   = 1'b1;
      end

      if (cmd.ins_tail) begin
         if (head_ff == NIL) begin
            head_in = cur_ff;
         end else begin
            nwr_en   = 1'b1;
            nwr_addr = tail_idx;
            nwr_data = cur_ff;
         end
         tail_in            = cur_ff;
         in_use_in[cur_idx] = 1'b1;
         count_in           = count_ff + CNT_W'(1);
      end

      if (cmd.rem_fwd) begin
         p_in = prev_rdata;
         n_in = next_val;
         if (prev_rdata != NIL) begin
            nwr_en   = 1'b1;
            nwr_addr = p_rd_idx;
            nwr_data = next_val;
         end else begin
            head_in = next_val;
         end
         nrd_en   = (fh_ff != NIL);
         nrd_addr = fh_idx;
      end

      if (cmd.rem_back) begin
         if (n_ff != NIL) begin
            prwr_en   = 1'b1;
            prwr_addr = n_idx;
            prwr_data = p_ff;
         end else begin
            tail_in = p_ff;
         end
         nwr_en   = 1'b1;
         nwr_data = (fh_ff == NIL) ? NIL : next_val;
      end

      if (cmd.rem_free) begin
         if (fh_ff != NIL) begin
            nwr_en   = 1'b1;
            nwr_addr = fh_idx;
            nwr_data = cur_ff;
         end else begin
            fh_in = cur_ff;
         end
         in_use_in[cur_idx] = 1'b0;
         count_in           = count_ff - CNT_W'(1);
      end

      if (cmd.rsp_load && cmd.rsp_dump) begin
         cur_in = next_val;
         k_in   = k_ff + DUMP_CNT_W'(1);
      end
   end

   always_comb begin
      nv_in = nv_ff;
      if (nwr_en) begin
         nv_in[nwr_addr] = 1'b1;
      end
   end

   always_comb begin
      rsp_slot_in  = (cmd.rsp_status == STAT_OK) ? cur_ext[SLOT_FIELD_W-1:0] : '0;
      rsp_pay_in   = cmd.rsp_dump ? pay_out_ext[DATA_W-1:0] : '0;
      rsp_last_in  = cmd.rsp_dump ? dmp_last : 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL;
         tail_ff      <= NIL;
         fh_ff        <= '0;
         count_ff     <= '0;
         in_use_ff    <= '0;
         nv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fh_ff        <= fh_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      pay_ff <= pay_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
      k_ff   <= k_in;
      if (nrd_en) begin
         nrd_v_ff <= nv_ff[nrd_addr];
         nrd_a_ff <= nrd_addr;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_cnt_ff    <= cnt_ext[COUNT_FIELD_W-1:0];
         rsp_last_ff   <= rsp_last_in;
      end
   end

   alle_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAPACITY)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nwr_en),
      .wr_addr (nwr_addr),
      .wr_data (nwr_data),
      .rd_en   (nrd_en),
      .rd_addr (nrd_addr),
      .rd_data (next_rdata)
   );

   alle_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAPACITY)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prwr_en),
      .wr_addr (prwr_addr),
      .wr_data (prwr_data),
      .rd_en   (cmd.rem_rd),
      .rd_addr (cur_idx),
      .rd_data (prev_rdata)
   );

   alle_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (CAPACITY)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_link),
      .wr_addr (cur_idx),
      .wr_data (pay_ff),
      .rd_en   (cmd.dmp_rd),
      .rd_addr (cur_idx),
      .rd_data (pay_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_USED_W){1'b0}},
                        rsp_cnt_ff, rsp_pay_ff, rsp_slot_ff, rsp_status_ff};

endmodule

/* rtl/alle_checker.sv */
// port level checks of the array linked list engine, bound to the top level
module alle_checker
   import alle_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_FIELD_W-1:0] rsp_count;
   logic [SLOT_FIELD_W+DATA_W-1:0] rsp_slot_pay;

   assign rsp_status   = rsp_tdata[STATUS_W-1:0];
   assign rsp_slot_pay = rsp_tdata[STATUS_W+SLOT_FIELD_W+DATA_W-1:STATUS_W];
   assign rsp_count    = rsp_tdata[RSP_USED_W-1:RSP_USED_W-COUNT_FIELD_W];

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // a real command leaves the engine busy in the cycle after it is taken
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != ACT_UNKNOWN) |=> !req_tready)
      else $error("command taken without busy cycle");

   // error results are single beats with no slot and no payload
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != STAT_OK) |-> rsp_tlast && (rsp_slot_pay == '0))
      else $error("error result not clean");

   // empty dump only with an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STAT_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with entries present");

   // only dump beats can be non-final
   a_mid_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_status == STAT_OK))
      else $error("non-final beat with error status");

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (.*);
